// ===== src/rcir_pkg.sv =====
// Package: widths, opcodes, state types and the compute microprogram.
package rcir_pkg;

	localparam int WORD_BITS    = 32;
	localparam int FRAC_BITS    = 16;
	localparam int NUM_OPERANDS = 36;
	localparam int REG_DEPTH    = 64;
	localparam int REG_AW       = $clog2(REG_DEPTH);
	localparam int IDX_BITS     = 6;
	localparam int KIND_BITS    = 3;
	localparam int PC_BITS      = 8;
	localparam int PROG_LEN     = 153;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_NEG, OP_ONE, OP_MUL, OP_DIV, OP_NORM,
		OP_SQSET, OP_SQACC, OP_SQRT, OP_EMX, OP_EMY, OP_EMZ
	} uop_op_t;

	typedef struct packed {
		uop_op_t           op;
		logic [REG_AW-1:0] dst;
		logic [REG_AW-1:0] a;
		logic [REG_AW-1:0] b;
	} uop_t;

	typedef struct packed {
		logic    start;
		uop_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		AL_IDLE, AL_ADD, AL_MUL, AL_RND, AL_DIV, AL_DIVR, AL_SQRT
	} alu_state_t;

	typedef enum logic [2:0] {
		SQ_IDLE, SQ_READ, SQ_ISSUE, SQ_WAIT, SQ_EMIT
	} seq_state_t;

	localparam logic [KIND_BITS-1:0] KIND_LIN  = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_ANGA = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_ANGB = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_SHA  = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_SHB  = 3'd4;

	function automatic uop_t uo(uop_op_t op, int unsigned d, int unsigned a, int unsigned b);
		uop_t r;
		r.op  = op;
		r.dst = REG_AW'(d);
		r.a   = REG_AW'(a);
		r.b   = REG_AW'(b);
		return r;
	endfunction

	// Register map: 0..35 operands, 36..63 temporaries.
	function automatic uop_t rcir_uop(logic [PC_BITS-1:0] pc);
		uop_t r;
		unique case (pc)
			8'd0:   r = uo(OP_SQSET, 63, 13, 0);
			8'd1:   r = uo(OP_SQACC, 63, 14, 0);
			8'd2:   r = uo(OP_SQACC, 63, 15, 0);
			8'd3:   r = uo(OP_SQRT, 63, 0, 0);
			8'd4:   r = uo(OP_NORM, 36, 13, 0);
			8'd5:   r = uo(OP_NORM, 37, 14, 0);
			8'd6:   r = uo(OP_NORM, 38, 15, 0);
			8'd7:   r = uo(OP_SUB, 39, 10, 4);
			8'd8:   r = uo(OP_SUB, 40, 11, 5);
			8'd9:   r = uo(OP_SUB, 41, 12, 6);
			8'd10:  r = uo(OP_SUB, 42, 10, 7);
			8'd11:  r = uo(OP_SUB, 43, 11, 8);
			8'd12:  r = uo(OP_SUB, 44, 12, 9);
			8'd13:  r = uo(OP_ONE, 45, 0, 0);
			8'd14:  r = uo(OP_MUL, 46, 2, 3);
			8'd15:  r = uo(OP_ADD, 46, 45, 46);
			8'd16:  r = uo(OP_MUL, 46, 46, 17);
			8'd17:  r = uo(OP_NEG, 46, 46, 0);
			8'd18:  r = uo(OP_DIV, 47, 45, 0);
			8'd19:  r = uo(OP_DIV, 48, 45, 1);
			8'd20:  r = uo(OP_ADD, 47, 47, 48);
			// body A: c = rA x n
			8'd21:  r = uo(OP_MUL, 52, 40, 38);
			8'd22:  r = uo(OP_MUL, 53, 41, 37);
			8'd23:  r = uo(OP_SUB, 49, 52, 53);
			8'd24:  r = uo(OP_MUL, 52, 41, 36);
			8'd25:  r = uo(OP_MUL, 53, 39, 38);
			8'd26:  r = uo(OP_SUB, 50, 52, 53);
			8'd27:  r = uo(OP_MUL, 52, 39, 37);
			8'd28:  r = uo(OP_MUL, 53, 40, 36);
			8'd29:  r = uo(OP_SUB, 51, 52, 53);
			// m = IA * c
			8'd30:  r = uo(OP_MUL, 52, 18, 49);
			8'd31:  r = uo(OP_MUL, 53, 19, 50);
			8'd32:  r = uo(OP_ADD, 52, 52, 53);
			8'd33:  r = uo(OP_MUL, 53, 20, 51);
			8'd34:  r = uo(OP_ADD, 54, 52, 53);
			8'd35:  r = uo(OP_MUL, 52, 21, 49);
			8'd36:  r = uo(OP_MUL, 53, 22, 50);
			8'd37:  r = uo(OP_ADD, 52, 52, 53);
			8'd38:  r = uo(OP_MUL, 53, 23, 51);
			8'd39:  r = uo(OP_ADD, 55, 52, 53);
			8'd40:  r = uo(OP_MUL, 52, 24, 49);
			8'd41:  r = uo(OP_MUL, 53, 25, 50);
			8'd42:  r = uo(OP_ADD, 52, 52, 53);
			8'd43:  r = uo(OP_MUL, 53, 26, 51);
			8'd44:  r = uo(OP_ADD, 56, 52, 53);
			// e = m x rA
			8'd45:  r = uo(OP_MUL, 52, 55, 41);
			8'd46:  r = uo(OP_MUL, 53, 56, 40);
			8'd47:  r = uo(OP_SUB, 49, 52, 53);
			8'd48:  r = uo(OP_MUL, 52, 56, 39);
			8'd49:  r = uo(OP_MUL, 53, 54, 41);
			8'd50:  r = uo(OP_SUB, 50, 52, 53);
			8'd51:  r = uo(OP_MUL, 52, 54, 40);
			8'd52:  r = uo(OP_MUL, 53, 55, 39);
			8'd53:  r = uo(OP_SUB, 51, 52, 53);
			// n . e
			8'd54:  r = uo(OP_MUL, 52, 36, 49);
			8'd55:  r = uo(OP_MUL, 53, 37, 50);
			8'd56:  r = uo(OP_ADD, 52, 52, 53);
			8'd57:  r = uo(OP_MUL, 53, 38, 51);
			8'd58:  r = uo(OP_ADD, 52, 52, 53);
			8'd59:  r = uo(OP_ADD, 47, 47, 52);
			// body B
			8'd60:  r = uo(OP_MUL, 52, 43, 38);
			8'd61:  r = uo(OP_MUL, 53, 44, 37);
			8'd62:  r = uo(OP_SUB, 49, 52, 53);
			8'd63:  r = uo(OP_MUL, 52, 44, 36);
			8'd64:  r = uo(OP_MUL, 53, 42, 38);
			8'd65:  r = uo(OP_SUB, 50, 52, 53);
			8'd66:  r = uo(OP_MUL, 52, 42, 37);
			8'd67:  r = uo(OP_MUL, 53, 43, 36);
			8'd68:  r = uo(OP_SUB, 51, 52, 53);
			8'd69:  r = uo(OP_MUL, 52, 27, 49);
			8'd70:  r = uo(OP_MUL, 53, 28, 50);
			8'd71:  r = uo(OP_ADD, 52, 52, 53);
			8'd72:  r = uo(OP_MUL, 53, 29, 51);
			8'd73:  r = uo(OP_ADD, 54, 52, 53);
			8'd74:  r = uo(OP_MUL, 52, 30, 49);
			8'd75:  r = uo(OP_MUL, 53, 31, 50);
			8'd76:  r = uo(OP_ADD, 52, 52, 53);
			8'd77:  r = uo(OP_MUL, 53, 32, 51);
			8'd78:  r = uo(OP_ADD, 55, 52, 53);
			8'd79:  r = uo(OP_MUL, 52, 33, 49);
			8'd80:  r = uo(OP_MUL, 53, 34, 50);
			8'd81:  r = uo(OP_ADD, 52, 52, 53);
			8'd82:  r = uo(OP_MUL, 53, 35, 51);
			8'd83:  r = uo(OP_ADD, 56, 52, 53);
			8'd84:  r = uo(OP_MUL, 52, 55, 44);
			8'd85:  r = uo(OP_MUL, 53, 56, 43);
			8'd86:  r = uo(OP_SUB, 49, 52, 53);
			8'd87:  r = uo(OP_MUL, 52, 56, 42);
			8'd88:  r = uo(OP_MUL, 53, 54, 44);
			8'd89:  r = uo(OP_SUB, 50, 52, 53);
			8'd90:  r = uo(OP_MUL, 52, 54, 43);
			8'd91:  r = uo(OP_MUL, 53, 55, 42);
			8'd92:  r = uo(OP_SUB, 51, 52, 53);
			8'd93:  r = uo(OP_MUL, 52, 36, 49);
			8'd94:  r = uo(OP_MUL, 53, 37, 50);
			8'd95:  r = uo(OP_ADD, 52, 52, 53);
			8'd96:  r = uo(OP_MUL, 53, 38, 51);
			8'd97:  r = uo(OP_ADD, 52, 52, 53);
			8'd98:  r = uo(OP_ADD, 47, 47, 52);
			8'd99:  r = uo(OP_DIV, 46, 46, 47);
			// J = j n
			8'd100: r = uo(OP_MUL, 57, 46, 36);
			8'd101: r = uo(OP_MUL, 58, 46, 37);
			8'd102: r = uo(OP_MUL, 59, 46, 38);
			// rA x J
			8'd103: r = uo(OP_MUL, 52, 40, 59);
			8'd104: r = uo(OP_MUL, 53, 41, 58);
			8'd105: r = uo(OP_SUB, 49, 52, 53);
			8'd106: r = uo(OP_MUL, 52, 41, 57);
			8'd107: r = uo(OP_MUL, 53, 39, 59);
			8'd108: r = uo(OP_SUB, 50, 52, 53);
			8'd109: r = uo(OP_MUL, 52, 39, 58);
			8'd110: r = uo(OP_MUL, 53, 40, 57);
			8'd111: r = uo(OP_SUB, 51, 52, 53);
			// -(rB x J)
			8'd112: r = uo(OP_MUL, 52, 43, 59);
			8'd113: r = uo(OP_MUL, 53, 44, 58);
			8'd114: r = uo(OP_SUB, 54, 52, 53);
			8'd115: r = uo(OP_MUL, 52, 44, 57);
			8'd116: r = uo(OP_MUL, 53, 42, 59);
			8'd117: r = uo(OP_SUB, 55, 52, 53);
			8'd118: r = uo(OP_MUL, 52, 42, 58);
			8'd119: r = uo(OP_MUL, 53, 43, 57);
			8'd120: r = uo(OP_SUB, 56, 52, 53);
			8'd121: r = uo(OP_NEG, 54, 54, 0);
			8'd122: r = uo(OP_NEG, 55, 55, 0);
			8'd123: r = uo(OP_NEG, 56, 56, 0);
			// separations
			8'd124: r = uo(OP_ADD, 46, 0, 1);
			8'd125: r = uo(OP_DIV, 47, 1, 46);
			8'd126: r = uo(OP_MUL, 47, 47, 16);
			8'd127: r = uo(OP_MUL, 60, 47, 13);
			8'd128: r = uo(OP_MUL, 61, 47, 14);
			8'd129: r = uo(OP_MUL, 62, 47, 15);
			8'd130: r = uo(OP_DIV, 47, 0, 46);
			8'd131: r = uo(OP_MUL, 47, 47, 16);
			8'd132: r = uo(OP_MUL, 39, 47, 13);
			8'd133: r = uo(OP_NEG, 39, 39, 0);
			8'd134: r = uo(OP_MUL, 40, 47, 14);
			8'd135: r = uo(OP_NEG, 40, 40, 0);
			8'd136: r = uo(OP_MUL, 41, 47, 15);
			8'd137: r = uo(OP_NEG, 41, 41, 0);
			// emit, kind in b
			8'd138: r = uo(OP_EMX, 0, 57, 0);
			8'd139: r = uo(OP_EMY, 0, 58, 0);
			8'd140: r = uo(OP_EMZ, 0, 59, int'(KIND_LIN));
			8'd141: r = uo(OP_EMX, 0, 49, 0);
			8'd142: r = uo(OP_EMY, 0, 50, 0);
			8'd143: r = uo(OP_EMZ, 0, 51, int'(KIND_ANGA));
			8'd144: r = uo(OP_EMX, 0, 54, 0);
			8'd145: r = uo(OP_EMY, 0, 55, 0);
			8'd146: r = uo(OP_EMZ, 0, 56, int'(KIND_ANGB));
			8'd147: r = uo(OP_EMX, 0, 60, 0);
			8'd148: r = uo(OP_EMY, 0, 61, 0);
			8'd149: r = uo(OP_EMZ, 0, 62, int'(KIND_SHA));
			8'd150: r = uo(OP_EMX, 0, 39, 0);
			8'd151: r = uo(OP_EMY, 0, 40, 0);
			8'd152: r = uo(OP_EMZ, 0, 41, int'(KIND_SHB));
			default: r = uo(OP_EMZ, 0, 41, int'(KIND_SHB));
		endcase
		return r;
	endfunction

endpackage

// ===== src/rcir_in_if.sv =====
// Input channel: valid/ready handshake with load/compute item payload.
interface rcir_in_if import rcir_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	logic [IDX_BITS-1:0] operand_index;
	word_t               operand_value;

	modport source (output valid, mode, operand_index, operand_value, input ready);
	modport sink (input valid, mode, operand_index, operand_value, output ready);
endinterface

// ===== src/rcir_out_if.sv =====
// Output channel: valid/ready handshake carrying one result vector per transfer.
interface rcir_out_if import rcir_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_BITS-1:0] kind;
	word_t                vec_x;
	word_t                vec_y;
	word_t                vec_z;
	logic                 overflow;
	logic                 last;

	modport source (output valid, kind, vec_x, vec_y, vec_z, overflow, last, input ready);
	modport sink (input valid, kind, vec_x, vec_y, vec_z, overflow, last, output ready);
endinterface

// ===== src/rigid_contact_impulse_response_unit.sv =====
// Contact impulse unit: a load item writes one operand word (an index of 36 or more is
// ignored); a compute item runs a fixed microprogram of 153 steps on one shared arithmetic
// unit and then emits five result vectors, each held until the output takes it. The
// largest share of a compute is the bit-serial divider (five divides and three
// normalizations; a zero divisor cuts a step short). The rest is the square root,
// 76 multiplies, 53 add-type steps and the emission of the result vectors.
// No item is taken while a compute runs.
module rigid_contact_impulse_response_unit import rcir_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	rcir_in_if.sink       cmd,
	rcir_out_if.source    res
);
	seq_state_t state_q, state_d;

	logic [PC_BITS-1:0]   pc_q;
	logic                 ovf_q;
	logic [KIND_BITS-1:0] kind_q;
	word_t                vx_q, vy_q, vz_q;
	uop_t                 uop;
	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	word_t                alu_res, rd_a, rd_b, wdata;
	logic                 we;
	logic [REG_AW-1:0]    waddr;
	logic                 load_ok;

	assign uop     = rcir_uop(pc_q);
	assign load_ok = cmd.operand_index < IDX_BITS'(NUM_OPERANDS);

	rcir_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_DEPTH)) u_ram_a (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(uop.a), .rdata(rd_a)
	);

	rcir_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_DEPTH)) u_ram_b (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(uop.b), .rdata(rd_b)
	);

	rcir_alu u_alu (
		.clk(clk), .arst_n(arst_n), .req(alu_req), .a(rd_a), .b(rd_b),
		.rsp(alu_rsp), .res(alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.ready   = 1'b0;
		res.valid   = 1'b0;
		alu_req     = '{start: 1'b0, op: uop.op};
		we          = 1'b0;
		waddr       = uop.dst;
		wdata       = alu_res;
		unique case (state_q)
			SQ_IDLE: begin
				cmd.ready = 1'b1;
				waddr     = cmd.operand_index[REG_AW-1:0];
				wdata     = cmd.operand_value;
				if (cmd.valid) begin
					if (cmd.mode) begin
						state_d = SQ_READ;
					end else begin
						we = load_ok;
					end
				end
			end
			SQ_READ: state_d = SQ_ISSUE;
			SQ_ISSUE: begin
				priority case (uop.op)
					OP_EMZ:         state_d = SQ_EMIT;
					OP_EMX, OP_EMY: state_d = SQ_READ;
					default: begin
						alu_req.start = 1'b1;
						state_d       = SQ_WAIT;
					end
				endcase
			end
			SQ_WAIT: begin
				if (alu_rsp.done) begin
					we      = 1'b1;
					state_d = SQ_READ;
				end
			end
			SQ_EMIT: begin
				res.valid = 1'b1;
				if (res.ready) begin
					state_d = (kind_q == KIND_SHB) ? SQ_IDLE : SQ_READ;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			ovf_q <= 1'b0;
		end else begin
			unique case (state_q)
				SQ_IDLE: begin
					if (cmd.valid && cmd.mode) begin
						pc_q  <= '0;
						ovf_q <= 1'b0;
					end
				end
				SQ_ISSUE: begin
					if (uop.op == OP_EMX || uop.op == OP_EMY) begin
						pc_q <= pc_q + 1'b1;
					end
				end
				SQ_WAIT: begin
					if (alu_rsp.done) begin
						pc_q  <= pc_q + 1'b1;
						ovf_q <= ovf_q | alu_rsp.sat;
					end
				end
				SQ_EMIT: begin
					if (res.ready) begin
						pc_q <= pc_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_ISSUE) begin
			unique case (uop.op)
				OP_EMX: vx_q <= rd_a;
				OP_EMY: vy_q <= rd_a;
				OP_EMZ: begin
					vz_q   <= rd_a;
					kind_q <= uop.b[KIND_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	assign res.kind     = kind_q;
	assign res.vec_x    = vx_q;
	assign res.vec_y    = vy_q;
	assign res.vec_z    = vz_q;
	assign res.overflow = ovf_q;
	assign res.last     = kind_q == KIND_SHB;
endmodule

// ===== src/rcir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rcir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/rcir_alu.sv =====
// Shared arithmetic unit: saturating add, rounded multiply, square accumulate, serial divide and square root.
module rcir_alu import rcir_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	input  word_t    a,
	input  word_t    b,
	output alu_rsp_t rsp,
	output word_t    res
);
	localparam int PW   = 2 * WORD_BITS;
	localparam int DW   = WORD_BITS + FRAC_BITS;
	localparam int MAGW = PW + 1 - FRAC_BITS;
	localparam int CW   = $clog2(DW);
	localparam int SW   = $clog2(WORD_BITS);

	alu_state_t state_q, state_d;

	uop_op_t                op_q;
	word_t                  a_q, b_q, res_q;
	logic                   done_q, sat_q, neg_q;
	logic [PW-1:0]          prod_q, acc_q;
	logic [DW-1:0]          dvd_q, quo_q;
	logic [WORD_BITS-1:0]   rem_q, div_q, len_q, root_q;
	logic [CW-1:0]          cnt_q;

	logic [WORD_BITS-1:0]   mul_x, mul_y, sq_c;
	logic [PW-1:0]          mul_p;
	logic [WORD_BITS:0]     sum;
	logic [WORD_BITS:0]     rem2;
	logic [PW:0]            rnd;
	logic [MAGW-1:0]        qrnd;

	function automatic logic [WORD_BITS-1:0] mag(word_t v);
		return v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
	endfunction

	// returns {sat, value}
	function automatic logic [WORD_BITS:0] mk(logic neg, logic [MAGW-1:0] m);
		logic [MAGW-1:0]      lim;
		logic [MAGW-1:0]      mm;
		logic                 s;
		lim = neg ? (MAGW'(1) << (WORD_BITS - 1)) : ((MAGW'(1) << (WORD_BITS - 1)) - 1'b1);
		s   = m > lim;
		mm  = s ? lim : m;
		return {s, neg ? WORD_BITS'(-mm[WORD_BITS-1:0]) : mm[WORD_BITS-1:0]};
	endfunction

	assign sq_c  = root_q | (WORD_BITS'(1) << cnt_q[SW-1:0]);
	assign mul_x = (state_q == AL_SQRT) ? sq_c : mag(a_q);
	assign mul_y = (state_q == AL_SQRT) ? sq_c :
		((op_q == OP_SQSET || op_q == OP_SQACC) ? mag(a_q) : mag(b_q));
	assign mul_p = mul_x * mul_y;

	always_comb begin
		unique case (op_q)
			OP_SUB:  sum = {a_q[WORD_BITS-1], a_q} - {b_q[WORD_BITS-1], b_q};
			OP_NEG:  sum = '0 - {a_q[WORD_BITS-1], a_q};
			OP_ONE:  sum = (WORD_BITS+1)'(1) << FRAC_BITS;
			default: sum = {a_q[WORD_BITS-1], a_q} + {b_q[WORD_BITS-1], b_q};
		endcase
	end

	assign rem2 = {rem_q, dvd_q[DW-1]};
	assign rnd  = {1'b0, prod_q} + ((PW+1)'(1) << (FRAC_BITS - 1));
	assign qrnd = MAGW'(quo_q) + MAGW'(({rem_q, 1'b0} >= {1'b0, div_q}) ? 1 : 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			AL_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						OP_MUL, OP_SQSET, OP_SQACC: state_d = AL_MUL;
						OP_DIV, OP_NORM:            state_d = AL_DIV;
						OP_SQRT:                    state_d = AL_SQRT;
						default:                    state_d = AL_ADD;
					endcase
				end
			end
			AL_ADD:  state_d = AL_IDLE;
			AL_MUL:  state_d = AL_RND;
			AL_RND:  state_d = AL_IDLE;
			AL_DIV: begin
				if (div_q == '0 || cnt_q == '0) begin
					state_d = AL_DIVR;
				end
			end
			AL_DIVR: state_d = AL_IDLE;
			AL_SQRT: begin
				if (cnt_q == '0) begin
					state_d = AL_IDLE;
				end
			end
			default: state_d = AL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == AL_ADD) || (state_q == AL_RND) || (state_q == AL_DIVR) ||
				(state_q == AL_SQRT && cnt_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			AL_IDLE: begin
				if (req.start) begin
					a_q    <= a;
					b_q    <= b;
					op_q   <= req.op;
					dvd_q  <= {mag(a), FRAC_BITS'(0)};
					rem_q  <= '0;
					quo_q  <= '0;
					root_q <= '0;
					div_q  <= (req.op == OP_NORM) ? len_q : mag(b);
					neg_q  <= a[WORD_BITS-1] ^ ((req.op != OP_NORM) & b[WORD_BITS-1]);
					cnt_q  <= (req.op == OP_SQRT) ? CW'(WORD_BITS - 1) : CW'(DW - 1);
				end
			end
			AL_ADD: begin
				sat_q <= sum[WORD_BITS] != sum[WORD_BITS-1];
				if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
					res_q <= sum[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
						: {1'b0, {(WORD_BITS-1){1'b1}}};
				end else begin
					res_q <= sum[WORD_BITS-1:0];
				end
			end
			AL_MUL: prod_q <= mul_p;
			AL_RND: begin
				if (op_q == OP_SQSET || op_q == OP_SQACC) begin
					acc_q <= ((op_q == OP_SQSET) ? '0 : acc_q) + prod_q;
					res_q <= '0;
					sat_q <= 1'b0;
				end else begin
					{sat_q, res_q} <= mk(a_q[WORD_BITS-1] ^ b_q[WORD_BITS-1],
						MAGW'(rnd >> FRAC_BITS));
				end
			end
			AL_DIV: begin
				if (div_q != '0) begin
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (rem2 >= {1'b0, div_q}) begin
						rem_q <= WORD_BITS'(rem2 - {1'b0, div_q});
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= rem2[WORD_BITS-1:0];
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
				end
			end
			AL_DIVR: begin
				if (div_q == '0) begin
					sat_q <= 1'b1;
					if (dvd_q == '0) begin
						res_q <= '0;
					end else begin
						res_q <= neg_q ? {1'b1, {(WORD_BITS-1){1'b0}}}
							: {1'b0, {(WORD_BITS-1){1'b1}}};
					end
				end else begin
					{sat_q, res_q} <= mk(neg_q, qrnd);
				end
			end
			AL_SQRT: begin
				cnt_q <= cnt_q - 1'b1;
				if (mul_p <= acc_q) begin
					root_q <= sq_c;
				end
				if (cnt_q == '0) begin
					len_q <= (mul_p <= acc_q) ? sq_c : root_q;
					res_q <= '0;
					sat_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign res      = res_q;
endmodule
